>>> hdl/clock_replacement_ring_assert.svh
// assertion macros for the clock replacement ring
`ifndef CLOCK_REPLACEMENT_RING_ASSERT_SVH
`define CLOCK_REPLACEMENT_RING_ASSERT_SVH
`ifndef SYNTHESIS
`define CRR_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("crr check failed");
`define CRR_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("crr check failed");
`else
`define CRR_ASSERT_IMP(lbl, clk, rst, a, b)
`define CRR_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

>>> hdl/crr_pkg.sv
// package for the clock replacement ring: types and constants
`timescale 1ns / 1ps
package crr_pkg;
  localparam int CRR_ENTRIES = 64;
  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    ACT_UPDATE  = 2'd0,
    ACT_SEARCH  = 2'd1,
    ACT_ENQUEUE = 2'd2,
    ACT_DEQUEUE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_UPD, ST_SRCH_PREV, ST_WALK, ST_ENQ_HAND,
    ST_ENQ_1, ST_ENQ_2, ST_ENQ_3, ST_ENQ_4, ST_ENQ_5, ST_DEQ, ST_RESULT
  } state_t;
endpackage

>>> hdl/crr_if.sv
// item channels for the clock replacement ring
`timescale 1ns / 1ps
interface crr_req_if import crr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [IDX_W-1:0] entry_index;
  logic             has_previous;
  logic [IDX_W-1:0] previous_index;
  logic             cached_in;
  logic             referenced_in;
  modport source (output valid, action, entry_index, has_previous, previous_index,
                  cached_in, referenced_in, input ready);
  modport sink (input valid, action, entry_index, has_previous, previous_index,
                cached_in, referenced_in, output ready);
endinterface

interface crr_rsp_if import crr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             victim_valid;
  logic [IDX_W-1:0] victim_index;
  modport source (output valid, victim_valid, victim_index, input ready);
  modport sink (input valid, victim_valid, victim_index, output ready);
endinterface

>>> hdl/clock_replacement_ring.sv
// top level of the clock replacement ring
// usage:
//   req carries one item per handshake: a status update, a victim search,
//   a transfer enqueue or an empty dequeue; rsp returns exactly one item
//   for each, with victim_valid and victim_index set only by a search.
//   ring links and marks live in two single-port-read, single-port-write
//   memories (next link with marks, and previous link), reads registered.
//   an update rewrites its entry's marks; an enqueue at the hand moves the
//   hand on, any other one relinks its entry just before the hand; a
//   dequeue clears referenced marks up to its entry, which becomes the hand;
//   a search walks the ring, up to two full passes of ENTRIES each. walks
//   read one entry per cycle; one item is worked on at a time.
//   after reset a link set-up pass over every entry runs; req.ready stays
//   low during it. every mark is clear and the hand is ENTRIES-1 after it.
//   a finished item waits in the rsp register; the next item is accepted
//   meanwhile, and only its own completion waits for rsp to be taken.
`timescale 1ns / 1ps
`include "clock_replacement_ring_assert.svh"
module clock_replacement_ring import crr_pkg::*; #(
  parameter int ENTRIES = CRR_ENTRIES
) (
  input logic       clk,
  input logic       rst,
  crr_req_if.sink   req,
  crr_rsp_if.source rsp
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AW = IW + 2;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic [AW-1:0] a_mem [ENTRIES];
  logic [IW-1:0] b_mem [ENTRIES];
  logic [AW-1:0] a_rdata;
  logic [IW-1:0] b_rdata;
  logic [IW-1:0] a_raddr, b_raddr, a_waddr, b_waddr;
  logic [AW-1:0] a_wdata;
  logic [IW-1:0] b_wdata;
  logic          a_we, b_we;

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    a_rdata <= a_mem[a_raddr];
  end
  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_waddr] <= b_wdata;
    b_rdata <= b_mem[b_raddr];
  end

  state_t        state, state_next;
  logic [IW-1:0] cnt, cnt_next;
  logic [IW-1:0] hand, hand_next;
  logic          sr, sr_next;
  logic          pass2, pass2_next;
  logic [IW-1:0] node, node_next;
  logic [IW-1:0] start, start_next;
  logic [IW-1:0] ent, ent_next;
  logic          cin, cin_next, rin, rin_next;
  logic [IW-1:0] tmp_a, tmp_a_next, tmp_b, tmp_b_next;
  logic [1:0]    marks, marks_next;
  logic          res_v, res_v_next;
  logic [IW-1:0] res_i, res_i_next;
  logic          ov, ov_next;
  logic          ovv, ovv_next;
  logic [IDX_W-1:0] oix, oix_next;

  logic [IW-1:0] d_nxt;
  logic          d_c, d_r;
  logic          e_ok, p_ok;
  logic [IW-1:0] e_ix, p_ix;

  assign d_nxt = a_rdata[AW-1:2];
  assign d_c   = a_rdata[1];
  assign d_r   = a_rdata[0];
  assign e_ok  = 32'(req.entry_index) < ENTRIES;
  assign p_ok  = 32'(req.previous_index) < ENTRIES;
  assign e_ix  = IW'(req.entry_index);
  assign p_ix  = IW'(req.previous_index);

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = ov;
  assign rsp.victim_valid = ovv;
  assign rsp.victim_index = oix;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      hand  <= LAST;
      sr    <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      hand  <= hand_next;
      sr    <= sr_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    pass2 <= pass2_next;
    node  <= node_next;
    start <= start_next;
    ent   <= ent_next;
    cin   <= cin_next;
    rin   <= rin_next;
    tmp_a <= tmp_a_next;
    tmp_b <= tmp_b_next;
    marks <= marks_next;
    res_v <= res_v_next;
    res_i <= res_i_next;
    ovv   <= ovv_next;
    oix   <= oix_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    hand_next  = hand;
    sr_next    = sr;
    pass2_next = pass2;
    node_next  = node;
    start_next = start;
    ent_next   = ent;
    cin_next   = cin;
    rin_next   = rin;
    tmp_a_next = tmp_a;
    tmp_b_next = tmp_b;
    marks_next = marks;
    res_v_next = res_v;
    res_i_next = res_i;
    ov_next    = ov && !rsp.ready;
    ovv_next   = ovv;
    oix_next   = oix;
    a_raddr    = node;
    b_raddr    = node;
    a_we       = 1'b0;
    a_waddr    = node;
    a_wdata    = a_rdata;
    b_we       = 1'b0;
    b_waddr    = node;
    b_wdata    = b_rdata;
    case (state)
      ST_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = cnt;
        a_wdata = {((cnt == '0) ? LAST : IW'(cnt - 1'b1)), 2'b00};
        b_we    = 1'b1;
        b_waddr = cnt;
        b_wdata = (cnt == LAST) ? '0 : IW'(cnt + 1'b1);
        cnt_next = IW'(cnt + 1'b1);
        if (cnt == LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        res_v_next = 1'b0;
        res_i_next = '0;
        ent_next   = e_ix;
        cin_next   = req.cached_in;
        rin_next   = req.referenced_in;
        if (req.valid) begin
          case (action_t'(req.action))
            ACT_SEARCH: begin
              pass2_next = sr;
              if (req.has_previous && p_ok) begin
                a_raddr    = p_ix;
                state_next = ST_SRCH_PREV;
              end else begin
                a_raddr    = hand;
                node_next  = hand;
                start_next = hand;
                state_next = ST_WALK;
              end
            end
            ACT_UPDATE: begin
              a_raddr    = e_ix;
              state_next = e_ok ? ST_UPD : ST_RESULT;
            end
            ACT_ENQUEUE: begin
              if (!e_ok) begin
                state_next = ST_RESULT;
              end else if (e_ix == hand) begin
                a_raddr    = hand;
                state_next = ST_ENQ_HAND;
              end else begin
                a_raddr    = e_ix;
                b_raddr    = e_ix;
                state_next = ST_ENQ_1;
              end
            end
            ACT_DEQUEUE: begin
              node_next  = sr ? e_ix : hand;
              a_raddr    = sr ? e_ix : hand;
              state_next = e_ok ? ST_DEQ : ST_RESULT;
            end
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_UPD: begin
        a_we       = 1'b1;
        a_waddr    = ent;
        a_wdata    = {d_nxt, cin, rin};
        state_next = ST_RESULT;
      end
      ST_SRCH_PREV: begin
        start_next = d_nxt;
        node_next  = d_nxt;
        a_raddr    = d_nxt;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (d_c && (pass2 || !d_r)) begin
          res_v_next = 1'b1;
          res_i_next = node;
          state_next = ST_RESULT;
        end else if (d_nxt == start) begin
          if (!pass2) begin
            sr_next    = 1'b1;
            pass2_next = 1'b1;
            node_next  = start;
            a_raddr    = start;
          end else begin
            sr_next    = 1'b0;
            state_next = ST_RESULT;
          end
        end else begin
          node_next = d_nxt;
          a_raddr   = d_nxt;
        end
      end
      ST_ENQ_HAND: begin
        hand_next  = d_nxt;
        state_next = ST_RESULT;
      end
      ST_ENQ_1: begin
        tmp_a_next = d_nxt;
        tmp_b_next = b_rdata;
        marks_next = {d_c, d_r};
        a_raddr    = b_rdata;
        state_next = ST_ENQ_2;
      end
      ST_ENQ_2: begin
        a_we       = 1'b1;
        a_waddr    = tmp_b;
        a_wdata    = {tmp_a, d_c, d_r};
        b_we       = 1'b1;
        b_waddr    = tmp_a;
        b_wdata    = tmp_b;
        state_next = ST_ENQ_3;
      end
      ST_ENQ_3: begin
        b_raddr    = hand;
        state_next = ST_ENQ_4;
      end
      ST_ENQ_4: begin
        tmp_b_next = b_rdata;
        b_we       = 1'b1;
        b_waddr    = ent;
        b_wdata    = b_rdata;
        a_we       = 1'b1;
        a_waddr    = ent;
        a_wdata    = {hand, marks};
        a_raddr    = b_rdata;
        state_next = ST_ENQ_5;
      end
      ST_ENQ_5: begin
        a_we       = 1'b1;
        a_waddr    = tmp_b;
        a_wdata    = {ent, d_c, d_r};
        b_we       = 1'b1;
        b_waddr    = hand;
        b_wdata    = ent;
        state_next = ST_RESULT;
      end
      ST_DEQ: begin
        a_we    = 1'b1;
        a_waddr = node;
        a_wdata = {d_nxt, d_c, 1'b0};
        if (d_nxt == ent) begin
          hand_next  = ent;
          sr_next    = 1'b0;
          state_next = ST_RESULT;
        end else begin
          node_next = d_nxt;
          a_raddr   = d_nxt;
        end
      end
      ST_RESULT: begin
        if (!ov || rsp.ready) begin
          ov_next    = 1'b1;
          ovv_next   = res_v;
          oix_next   = res_v ? IDX_W'(res_i) : '0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CRR_ASSERT_NXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready)
  `CRR_ASSERT_IMP(a_no_accept_in_clear, clk, rst, state == ST_CLEAR, !req.ready)
  `CRR_ASSERT_IMP(a_invalid_zero, clk, rst, rsp.valid && !rsp.victim_valid,
                  rsp.victim_index == '0)
endmodule

>>> tb/sv/clock_replacement_ring_checker.sv
// checker for the clock replacement ring: ring predictor and result comparison
`timescale 1ns / 1ps
module clock_replacement_ring_checker import crr_pkg::*; (
  input logic      clk,
  input logic      rst,
  crr_req_if.sink  req_mon,
  crr_rsp_if.sink  rsp_mon,
  output int       fail_count,
  output int       pending_count
);
  localparam int N = CRR_ENTRIES;

  typedef struct packed {
    logic             victim_valid;
    logic [IDX_W-1:0] victim_index;
  } victim_t;

  logic [IDX_W-1:0] nxt [N];
  logic [IDX_W-1:0] prv [N];
  logic [IDX_W-1:0] hand;
  logic             second_pass;
  logic             cached [N];
  logic             refd [N];
  victim_t          expected_victims [$];

  assign pending_count = expected_victims.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic walk(input logic [IDX_W-1:0] start, input logic need_unref,
                                output logic [IDX_W-1:0] found);
    logic [IDX_W-1:0] node;
    node = start;
    found = '0;
    for (int n = 0; n < N; n++) begin
      if (cached[node] && (!need_unref || !refd[node])) begin
        found = node;
        return 1'b1;
      end
      node = nxt[node];
      if (node == start) break;
    end
    return 1'b0;
  endfunction

  function automatic victim_t apply_request(input action_t act, input logic [IDX_W-1:0] e,
                                            input logic has_prev, input logic [IDX_W-1:0] p,
                                            input logic c, input logic r);
    victim_t v;
    logic [IDX_W-1:0] start, found, b, a, node;
    v = '0;
    case (act)
      ACT_SEARCH: begin
        start = has_prev ? nxt[p] : hand;
        if (!second_pass && walk(start, 1'b1, found)) begin
          v = {1'b1, found};
        end else begin
          second_pass = 1'b1;
          if (walk(start, 1'b0, found)) v = {1'b1, found};
          else second_pass = 1'b0;
        end
      end
      ACT_UPDATE: begin
        cached[e] = c;
        refd[e] = r;
      end
      ACT_ENQUEUE: begin
        if (e == hand) begin
          hand = nxt[hand];
        end else begin
          b = prv[e];
          a = nxt[e];
          nxt[b] = a;
          prv[a] = b;
          b = prv[hand];
          prv[e] = b;
          nxt[e] = hand;
          nxt[b] = e;
          prv[hand] = e;
        end
      end
      default: begin
        node = second_pass ? e : hand;
        for (int n = 0; n < N; n++) begin
          refd[node] = 1'b0;
          node = nxt[node];
          if (node == e) break;
        end
        second_pass = 1'b0;
        hand = e;
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    victim_t want;
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        nxt[i] = IDX_W'((i + N - 1) % N);
        prv[i] = IDX_W'((i + 1) % N);
        cached[i] = 1'b0;
        refd[i] = 1'b0;
      end
      hand = IDX_W'(N - 1);
      second_pass = 1'b0;
      expected_victims.delete();
      fail_count = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_victims.size() == 0) begin
          report_mismatch("unexpected item", rsp_mon.victim_index, 0);
        end else begin
          want = expected_victims.pop_front();
          if (rsp_mon.victim_valid !== want.victim_valid)
            report_mismatch("victim_valid", rsp_mon.victim_valid, want.victim_valid);
          if (rsp_mon.victim_index !== want.victim_index)
            report_mismatch("victim_index", rsp_mon.victim_index, want.victim_index);
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_victims.push_back(apply_request(action_t'(req_mon.action),
            req_mon.entry_index, req_mon.has_previous, req_mon.previous_index,
            req_mon.cached_in, req_mon.referenced_in));
    end
  end
endmodule

>>> tb/sv/clock_replacement_ring_tb.sv
// testbench top for the clock replacement ring: stimulus, stalls and verdict
`timescale 1ns / 1ps
module clock_replacement_ring_tb;
  import crr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  logic idle_free = 1'b0;
  int   rsp_wait;

  crr_req_if req ();
  crr_rsp_if rsp ();

  clock_replacement_ring u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  clock_replacement_ring_checker u_chk (.clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp),
                                        .fail_count(fail_count),
                                        .pending_count(pending_count));

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.action = '0;
    req.entry_index = '0;
    req.has_previous = 1'b0;
    req.previous_index = '0;
    req.cached_in = 1'b0;
    req.referenced_in = 1'b0;
    rsp.ready = 1'b0;
  end

  task automatic send_item(input action_t act, input int e, input logic hp, input int p,
                           input logic c, input logic r);
    int gap;
    gap = idle_free ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.entry_index <= IDX_W'(e);
    req.has_previous <= hp;
    req.previous_index <= IDX_W'(p);
    req.cached_in <= c;
    req.referenced_in <= r;
    do @(posedge clk); while (!req.ready);
  endtask

  // receiver waits a drawn number of cycles for every item
  always @(posedge clk) begin
    int w;
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_wait  <= 0;
    end else begin
      w = rsp_wait;
      if (rsp.valid && rsp.ready) w = idle_free ? 0 : $urandom_range(0, 12);
      else if (rsp.valid && w > 0) w = w - 1;
      rsp_wait  <= w;
      rsp.ready <= (w == 0);
    end
  end

  initial begin
    int sel;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed part
    send_item(ACT_SEARCH, 0, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_UPDATE, 63, 1'b0, 0, 1'b1, 1'b1);
    send_item(ACT_UPDATE, 0, 1'b0, 0, 1'b1, 1'b0);
    send_item(ACT_SEARCH, 0, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_SEARCH, 0, 1'b1, 63, 1'b0, 1'b0);
    send_item(ACT_UPDATE, 0, 1'b0, 0, 1'b1, 1'b1);
    send_item(ACT_SEARCH, 0, 1'b1, 0, 1'b0, 1'b0);
    send_item(ACT_SEARCH, 0, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_DEQUEUE, 10, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_ENQUEUE, 10, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_ENQUEUE, 0, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_ENQUEUE, 63, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_DEQUEUE, 9, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_UPDATE, 63, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_UPDATE, 0, 1'b0, 0, 1'b0, 1'b0);
    send_item(ACT_SEARCH, 0, 1'b1, 42, 1'b0, 1'b0);
    // random part
    for (int i = 0; i < 1000; i++) begin
      if (i % 200 == 100) idle_free = 1'b1;
      if (i % 200 == 150) idle_free = 1'b0;
      sel = $urandom_range(0, 9);
      if (sel < 4)
        send_item(ACT_UPDATE, $urandom_range(0, 63), 1'b0, $urandom_range(0, 63),
                  $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      else if (sel < 7)
        send_item(ACT_SEARCH, $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else if (sel < 9)
        send_item(ACT_ENQUEUE, $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        send_item(ACT_DEQUEUE, $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
    req.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
